[rtl/core/ale_pkg.sv]
// ---------------------------------------------------------------------------
// ale_pkg: shared types and codes for the list edit engine
// Request and result words, request kinds, status codes, prime tester words, capacity default.
// ---------------------------------------------------------------------------
package ale_pkg;

	localparam int unsigned DEF_CAPACITY = 64;
	localparam int unsigned PosW = 7;

	localparam logic [2:0] K_INSERT   = 3'd0;
	localparam logic [2:0] K_DEL_AT   = 3'd1;
	localparam logic [2:0] K_DEL_HEAD = 3'd2;
	localparam logic [2:0] K_DEL_TAIL = 3'd3;
	localparam logic [2:0] K_DEL_ONE  = 3'd4;
	localparam logic [2:0] K_DEL_ALL  = 3'd5;
	localparam logic [2:0] K_DEL_PRM  = 3'd6;
	localparam logic [2:0] K_READ     = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPOS   = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [6:0]         count_after;
		logic [6:0]         removed;
		logic signed [31:0] read_value;
	} rsp_t;

	// control from sequencer to prime tester
	typedef struct packed {
		logic        start;
		logic [31:0] x;
	} prm_req_t;

	// answer from prime tester
	typedef struct packed {
		logic done;
		logic prime;
	} prm_rsp_t;

endpackage

[rtl/core/ale_prime.sv]
// ---------------------------------------------------------------------------
// ale_prime: trial-division primality tester
// Steps divisors d = 2, 3, ... while d*d <= x; each remainder is found by a
// restoring divider that takes one dividend bit per cycle.
// ---------------------------------------------------------------------------
module ale_prime (
	input  logic             clk,
	input  logic             arst_n,
	input  ale_pkg::prm_req_t preq,
	output ale_pkg::prm_rsp_t prsp
);
	import ale_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_CHK  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_REM  = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] x_q;
	logic [16:0] d_q;
	logic [32:0] sq_q;
	logic [16:0] rem_q;
	logic [4:0]  bit_q;
	logic        done_q;
	logic        prime_q;
	logic [17:0] trial;

	// shift in the next dividend bit
	assign trial = {rem_q, x_q[bit_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (preq.start && ($signed(preq.x) < 32'sd2)) begin
						done_q  <= 1'b1;
						prime_q <= 1'b0;
					end else begin
						done_q <= 1'b0;
						if (preq.start) state_q <= P_CHK;
					end
				end
				P_CHK: begin
					if (sq_q > {1'b0, x_q}) begin
						done_q  <= 1'b1;
						prime_q <= 1'b1;
						state_q <= P_IDLE;
					end else begin
						done_q  <= 1'b0;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					done_q <= 1'b0;
					if (bit_q == 5'd0) state_q <= P_REM;
				end
				P_REM: begin
					if (rem_q == 17'd0) begin
						done_q  <= 1'b1;
						prime_q <= 1'b0;
						state_q <= P_IDLE;
					end else begin
						done_q  <= 1'b0;
						state_q <= P_CHK;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	// datapath: divisor, its square, remainder
	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				x_q  <= preq.x;
				d_q  <= 17'd2;
				sq_q <= 33'd4;
			end
			P_CHK: begin
				rem_q <= 17'd0;
				bit_q <= 5'd31;
			end
			P_DIV: begin
				if (trial >= {1'b0, d_q}) rem_q <= 17'(trial - {1'b0, d_q});
				else rem_q <= trial[16:0];
				bit_q <= bit_q - 5'd1;
			end
			P_REM: begin
				// (d+1)^2 = d^2 + 2d + 1
				d_q  <= d_q + 17'd1;
				sq_q <= sq_q + {15'd0, d_q, 1'b0} + 33'd1;
			end
			default: ;
		endcase
	end

	assign prsp.done  = done_q;
	assign prsp.prime = prime_q;

endmodule

[rtl/core/array_list_edit_engine.sv]
// Shifts read and write back each moved entry in turn, match scans read and
// compare one entry at a time, and prime delete runs the prime tester on
// each entry. One request is worked at a time; the list memory (one read or
// one write per cycle, on separate read and write ports) sets the pace.
// Reset clears the count and control; list contents are not cleared.
// ---------------------------------------------------------------------------
// array_list_edit_engine: packed list of signed words with edit requests
// A sequencer reads, moves and writes entries of one synchronous memory.
// ---------------------------------------------------------------------------
module array_list_edit_engine #(
	parameter int unsigned CAPACITY = ale_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ale_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ale_pkg::rsp_t rsp
);
	import ale_pkg::*;

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CMPW = ((CW > PosW) ? CW : PosW) + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INS_RD = 4'd1;
	localparam logic [3:0] S_INS_WB = 4'd2;
	localparam logic [3:0] S_INS_WR = 4'd3;
	localparam logic [3:0] S_SH     = 4'd4;
	localparam logic [3:0] S_SH_WB  = 4'd5;
	localparam logic [3:0] S_FM_RD  = 4'd6;
	localparam logic [3:0] S_FM_CMP = 4'd7;
	localparam logic [3:0] S_CP_RD  = 4'd8;
	localparam logic [3:0] S_CP_TST = 4'd9;
	localparam logic [3:0] S_CP_WT  = 4'd10;
	localparam logic [3:0] S_RD_WT  = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [3:0]    state_q;
	logic [2:0]    kind_q;
	logic [31:0]   value_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] removed_q;
	logic [2:0]    status_q;
	logic [31:0]   rd_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// list memory
	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata;
	logic          re;
	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd;

	prm_req_t preq;
	prm_rsp_t prsp;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic            accept;
	logic            drop_match;
	logic            slot_free;

	assign pos_x     = CMPW'(req.position);
	assign cnt_x     = CMPW'(cnt_q);
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign drop_match = (rdata == value_q);

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata <= mem[ra];
	end

	ale_prime u_prime (
		.clk    (clk),
		.arst_n (arst_n),
		.preq   (preq),
		.prsp   (prsp)
	);

	// memory port control
	always_comb begin
		re = 1'b0;
		ra = i_q[AW-1:0];
		we = 1'b0;
		wa = i_q[AW-1:0];
		wd = rdata;
		preq.start = 1'b0;
		preq.x     = rdata;
		case (state_q)
			S_IDLE: begin
				re = accept && (req.kind == K_READ);
				ra = AW'(req.position);
			end
			S_INS_RD: begin
				re = 1'b1;
				ra = AW'(i_q - CW'(1));
			end
			S_INS_WB: we = 1'b1;
			S_INS_WR: begin
				we = 1'b1;
				wa = pos_q[AW-1:0];
				wd = value_q;
			end
			S_SH: begin
				re = (CW'(i_q + CW'(1)) < cnt_q);
				ra = AW'(i_q + CW'(1));
			end
			S_SH_WB: we = 1'b1;
			S_FM_RD, S_CP_RD: re = (i_q < cnt_q);
			S_CP_TST: begin
				preq.start = (kind_q == K_DEL_PRM);
				if (kind_q == K_DEL_ALL) begin
					we = !drop_match;
					wa = j_q[AW-1:0];
				end
			end
			S_CP_WT: begin
				we = prsp.done && !prsp.prime;
				wa = j_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// raise the result word when finished, drop it once taken
			if (state_q == S_FIN && slot_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.kind)
							K_INSERT: begin
								if (pos_x > cnt_x) state_q <= S_FIN;
								else if (cnt_q == CW'(CAPACITY)) state_q <= S_FIN;
								else if (CMPW'(cnt_q) == pos_x) state_q <= S_INS_WR;
								else state_q <= S_INS_RD;
							end
							K_DEL_AT: begin
								if (pos_x >= cnt_x) state_q <= S_FIN;
								else state_q <= S_SH;
							end
							K_DEL_HEAD: begin
								state_q <= (cnt_q == '0) ? S_FIN : S_SH;
							end
							K_DEL_TAIL: begin
								if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
								state_q <= S_FIN;
							end
							K_DEL_ONE: state_q <= S_FM_RD;
							K_DEL_ALL, K_DEL_PRM: state_q <= S_CP_RD;
							default: begin
								state_q <= (pos_x >= cnt_x) ? S_FIN : S_RD_WT;
							end
						endcase
					end
				end
				S_INS_RD: state_q <= S_INS_WB;
				S_INS_WB: begin
					if (CW'(i_q - CW'(1)) == pos_q) state_q <= S_INS_WR;
					else state_q <= S_INS_RD;
				end
				S_INS_WR: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FIN;
				end
				S_SH: begin
					if (CW'(i_q + CW'(1)) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_SH_WB;
					end
				end
				S_SH_WB: state_q <= S_SH;
				S_FM_RD: state_q <= (i_q < cnt_q) ? S_FM_CMP : S_FIN;
				S_FM_CMP: state_q <= drop_match ? S_SH : S_FM_RD;
				S_CP_RD: begin
					if (i_q >= cnt_q) begin
						cnt_q   <= j_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CP_TST;
					end
				end
				S_CP_TST: state_q <= (kind_q == K_DEL_PRM) ? S_CP_WT : S_CP_RD;
				S_CP_WT: if (prsp.done) state_q <= S_CP_RD;
				S_RD_WT: state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request fields, indexes and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q    <= req.kind;
				value_q   <= req.value;
				pos_q     <= CW'(req.position);
				rd_q      <= '0;
				j_q       <= '0;
				case (req.kind)
					K_INSERT: begin
						i_q       <= cnt_q;
						removed_q <= '0;
						if (pos_x > cnt_x) status_q <= ST_BADPOS;
						else if (cnt_q == CW'(CAPACITY)) status_q <= ST_FULL;
						else status_q <= ST_OK;
					end
					K_DEL_AT: begin
						i_q <= CW'(req.position);
						if (pos_x >= cnt_x) begin
							status_q  <= ST_BADPOS;
							removed_q <= '0;
						end else begin
							status_q  <= ST_OK;
							removed_q <= CW'(1);
						end
					end
					K_DEL_HEAD, K_DEL_TAIL: begin
						i_q <= '0;
						if (cnt_q == '0) begin
							status_q  <= ST_EMPTY;
							removed_q <= '0;
						end else begin
							status_q  <= ST_OK;
							removed_q <= CW'(1);
						end
					end
					K_READ: begin
						i_q       <= '0;
						removed_q <= '0;
						status_q  <= (pos_x >= cnt_x) ? ST_BADPOS : ST_OK;
					end
					default: begin
						i_q       <= '0;
						removed_q <= '0;
						status_q  <= ST_OK;
					end
				endcase
			end
			S_INS_WB: i_q <= i_q - CW'(1);
			S_SH_WB:  i_q <= i_q + CW'(1);
			S_FM_RD: if (i_q >= cnt_q) status_q <= ST_NOTFOUND;
			S_FM_CMP: begin
				if (drop_match) removed_q <= CW'(1);
				else i_q <= i_q + CW'(1);
			end
			S_CP_RD: begin
				if (i_q >= cnt_q) begin
					removed_q <= cnt_q - j_q;
					if (kind_q == K_DEL_ALL && cnt_q == j_q) status_q <= ST_NOTFOUND;
				end
			end
			S_CP_TST: begin
				if (kind_q == K_DEL_ALL) begin
					i_q <= i_q + CW'(1);
					if (!drop_match) j_q <= j_q + CW'(1);
				end
			end
			S_CP_WT: begin
				if (prsp.done) begin
					i_q <= i_q + CW'(1);
					if (!prsp.prime) j_q <= j_q + CW'(1);
				end
			end
			S_RD_WT: rd_q <= rdata;
			S_FIN: begin
				if (slot_free) begin
					rsp_q.status      <= status_q;
					rsp_q.count_after <= 7'(cnt_q);
					rsp_q.removed     <= 7'(removed_q);
					rsp_q.read_value  <= rd_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/core/ale_checker.sv]
// ---------------------------------------------------------------------------
// ale_checker: port-level checks for the list edit engine
// Watches result words for consistency and the stall rule on the output.
// ---------------------------------------------------------------------------
module ale_checker #(
	parameter int unsigned CAPACITY = ale_pkg::DEF_CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ale_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ale_pkg::rsp_t rsp
);
	import ale_pkg::*;

	// failed requests remove nothing and read nothing
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.removed == 7'd0 && rsp.read_value == 32'sd0)
		else $error("failed request reports removal or data");

	// count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.count_after) <= CAPACITY)
		else $error("count above capacity");

	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_FULL)
		else $error("bad status code");

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

bind array_list_edit_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (.*);
